// ----- sv/scbp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, register indexes and constants of the capsule brush pixel pipeline.
package scbp_pkg;

    localparam int QW      = 16;
    localparam int D2W     = 48;
    localparam int RW      = 24;
    localparam int TDIV_W  = 51;
    localparam int CDIV_W  = 24;
    localparam int BLEND_N = 4;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [2:0] REG_START    = 3'd0;
    localparam logic [2:0] REG_END      = 3'd1;
    localparam logic [2:0] REG_RADIUS   = 3'd2;
    localparam logic [2:0] REG_HARDNESS = 3'd3;
    localparam logic [2:0] REG_OPACITY  = 3'd4;
    localparam logic [2:0] REG_PAINT    = 3'd5;
    localparam logic [2:0] REG_CANVAS   = 3'd6;

    localparam logic [1:0] T_ZERO = 2'd0;
    localparam logic [1:0] T_ONE  = 2'd1;
    localparam logic [1:0] T_DIV  = 2'd2;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [31:0]        orig_rgba;
        logic [31:0]        prev_rgba;
        logic [16:0]        prev_coverage;
    } in_t;

    typedef struct packed {
        logic [31:0] new_rgba;
        logic [16:0] new_coverage;
        logic        write_enable;
        logic        pixel_changed;
    } out_t;

    typedef struct packed {
        logic [31:0] orig_rgba;
        logic [31:0] prev_rgba;
        logic [16:0] prev_coverage;
        logic        ok;
    } pix_t;

    typedef struct packed {
        pix_t               pix;
        logic signed [24:0] ux;
        logic signed [24:0] uy;
        logic signed [24:0] vx;
        logic signed [24:0] vy;
        logic [1:0]         tmode;
    } side_t_t;

    typedef struct packed {
        pix_t pix;
        logic full;
    } side_c_t;

endpackage

// ----- sv/scbp_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, numerator below denominator.
module scbp_div #(
    parameter int W  = 24,
    parameter int SB = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [W-1:0]          num,
    input  logic [W-1:0]          den,
    input  logic [SB-1:0]         side_in,
    output logic                  out_valid,
    output logic [scbp_pkg::QW-1:0] quo,
    output logic [SB-1:0]         side_out
);
    import scbp_pkg::*;

    logic          valid_reg [QW];
    logic [W-1:0]  rem_reg   [QW];
    logic [W-1:0]  den_reg   [QW];
    logic [QW-1:0] q_reg     [QW];
    logic [SB-1:0] side_reg  [QW];

    genvar i;
    generate
        for (i = 0; i < QW; i++) begin : g_stage
            logic          v_in;
            logic [W-1:0]  r_in;
            logic [W-1:0]  d_in;
            logic [QW-1:0] q_in;
            logic [SB-1:0] s_in;
            logic [W:0]    sh;
            logic          ge;
            logic [W-1:0]  rem_next;
            if (i == 0) begin : g_first
                assign v_in = in_valid;
                assign r_in = num;
                assign d_in = den;
                assign q_in = '0;
                assign s_in = side_in;
            end else begin : g_rest
                assign v_in = valid_reg[i-1];
                assign r_in = rem_reg[i-1];
                assign d_in = den_reg[i-1];
                assign q_in = q_reg[i-1];
                assign s_in = side_reg[i-1];
            end
            assign sh       = {r_in, 1'b0};
            assign ge       = sh >= {1'b0, d_in};
            assign rem_next = ge ? W'(sh - {1'b0, d_in}) : sh[W-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else
                begin
                    valid_reg[i] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= d_in;
                q_reg[i]    <= {q_in[QW-2:0], ge};
                side_reg[i] <= s_in;
            end
        end
    endgenerate

    assign out_valid = valid_reg[QW-1];
    assign quo       = q_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

// ----- sv/scbp_sqrt.sv -----
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
module scbp_sqrt #(
    parameter int SB = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [scbp_pkg::D2W-1:0] val,
    input  logic [SB-1:0]            side_in,
    output logic                     out_valid,
    output logic [scbp_pkg::RW-1:0]  root,
    output logic [SB-1:0]            side_out
);
    import scbp_pkg::*;

    logic           valid_reg [RW];
    logic [D2W-1:0] val_reg   [RW];
    logic [RW+1:0]  rem_reg   [RW];
    logic [RW-1:0]  root_reg  [RW];
    logic [SB-1:0]  side_reg  [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_stage
            logic           v_in;
            logic [D2W-1:0] x_in;
            logic [RW+1:0]  r_in;
            logic [RW-1:0]  q_in;
            logic [SB-1:0]  s_in;
            logic [RW+3:0]  cand;
            logic [RW+3:0]  trial;
            logic           ge;
            logic [RW+3:0]  diff;
            if (k == 0) begin : g_first
                assign v_in = in_valid;
                assign x_in = val;
                assign r_in = '0;
                assign q_in = '0;
                assign s_in = side_in;
            end else begin : g_rest
                assign v_in = valid_reg[k-1];
                assign x_in = val_reg[k-1];
                assign r_in = rem_reg[k-1];
                assign q_in = root_reg[k-1];
                assign s_in = side_reg[k-1];
            end
            assign cand  = {r_in, x_in[D2W-1:D2W-2]};
            assign trial = {2'b00, q_in, 2'b01};
            assign ge    = cand >= trial;
            assign diff  = cand - trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else
                begin
                    valid_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                val_reg[k]  <= {x_in[D2W-3:0], 2'b00};
                rem_reg[k]  <= ge ? diff[RW+1:0] : cand[RW+1:0];
                root_reg[k] <= {q_in[RW-2:0], ge};
                side_reg[k] <= s_in;
            end
        end
    endgenerate

    assign out_valid = valid_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

// ----- sv/scbp_blend.sv -----
`timescale 1ns / 1ps
// Coverage update, alpha, per-channel blend and result register.
module scbp_blend (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [scbp_pkg::QW-1:0] quo,
    input  scbp_pkg::side_c_t      side,
    input  logic [16:0]            opacity,
    input  logic [24:0]            paint,
    output logic                   done,
    output scbp_pkg::out_t         result
);
    import scbp_pkg::*;

    logic        b1_valid_reg, b2_valid_reg, b3_valid_reg, done_reg;
    pix_t        b1_pix_reg, b2_pix_reg, b3_pix_reg;
    logic [16:0] b1_value_reg, b2_value_reg, b3_value_reg;
    logic        b1_raise_reg, b2_raise_reg, b3_raise_reg;
    logic [16:0] b2_a_reg;
    logic [31:0] b3_rgba_reg;
    out_t        result_reg;

    logic [16:0] value_next;
    logic [33:0] aprod;
    logic [16:0] inv;
    logic [31:0] rgba_next;
    out_t        result_next;

    assign value_next = side.full ? ONE_Q16 : {1'b0, quo};
    assign aprod      = b1_value_reg * opacity + 34'd32768;
    assign inv        = ONE_Q16 - b2_a_reg;

    always_comb
    begin
        logic [7:0]  src;
        logic [7:0]  pnt;
        logic [24:0] s;
        rgba_next = '0;
        for (int c = 0; c < 4; c++)
        begin
            src = b2_pix_reg.orig_rgba[8*c +: 8];
            pnt = (c == 3) ? 8'hFF : paint[8*c +: 8];
            s   = 25'(src) * 25'(inv) + 25'd32768;
            if (!paint[24])
            begin
                s = s + 25'(pnt) * 25'(b2_a_reg);
            end
            rgba_next[8*c +: 8] = (s[24:16] > 9'd255) ? 8'hFF : s[23:16];
        end
    end

    always_comb
    begin
        if (b3_raise_reg)
        begin
            result_next.new_rgba      = b3_rgba_reg;
            result_next.new_coverage  = b3_value_reg;
            result_next.write_enable  = 1'b1;
            result_next.pixel_changed = b3_rgba_reg != b3_pix_reg.prev_rgba;
        end
        else
        begin
            result_next.new_rgba      = b3_pix_reg.prev_rgba;
            result_next.new_coverage  = b3_pix_reg.prev_coverage;
            result_next.write_enable  = 1'b0;
            result_next.pixel_changed = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= in_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            done_reg     <= b3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_pix_reg   <= side.pix;
        b1_value_reg <= value_next;
        b1_raise_reg <= side.pix.ok && (value_next > side.pix.prev_coverage);
        b2_pix_reg   <= b1_pix_reg;
        b2_value_reg <= b1_value_reg;
        b2_raise_reg <= b1_raise_reg;
        b2_a_reg     <= aprod[32:16];
        b3_pix_reg   <= b2_pix_reg;
        b3_value_reg <= b2_value_reg;
        b3_raise_reg <= b2_raise_reg;
        b3_rgba_reg  <= rgba_next;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- sv/swept_circle_brush_pixel_top.sv -----
`timescale 1ns / 1ps
// Capsule brush pixel pipeline: config registers, geometry stages, dividers and root.
// Every accepted beat yields one done strobe, after the geometry, divider, root and blend stages.
// Throughput: one beat per cycle; busy stays low, set by the fully pipelined
// quotient, root and blend stages (16 + 24 + 16 + 4 bit-step and blend registers).
// Reset: valid bits cleared, registers at their reset values (opacity 1.0, rest 0).
// The receiver cannot stall; each result shows for exactly one cycle.
module swept_circle_brush_pixel_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  scbp_pkg::in_t   item,
    output logic            done,
    output scbp_pkg::out_t  result,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [47:0]     cfg_data
);
    import scbp_pkg::*;

    localparam int Lat = 4 + QW + 4 + RW + 1 + QW + BLEND_N;

    logic [47:0] start_reg, end_reg;
    logic [23:0] radius_reg;
    logic [16:0] hard_reg, opac_reg;
    logic [24:0] paint_reg;
    logic [31:0] canvas_reg;
    logic [47:0] r2_reg;
    logic [23:0] inner_reg;
    logic [16:0] opsat_reg;

    logic [16:0] hsat;
    logic [40:0] inner_prod;

    assign busy       = 1'b0;
    assign hsat       = (hard_reg > ONE_Q16) ? ONE_Q16 : hard_reg;
    assign inner_prod = radius_reg * hsat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            end_reg    <= '0;
            radius_reg <= '0;
            hard_reg   <= '0;
            opac_reg   <= ONE_Q16;
            paint_reg  <= '0;
            canvas_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START:    start_reg  <= cfg_data;
                REG_END:      end_reg    <= cfg_data;
                REG_RADIUS:   radius_reg <= cfg_data[23:0];
                REG_HARDNESS: hard_reg   <= cfg_data[16:0];
                REG_OPACITY:  opac_reg   <= cfg_data[16:0];
                REG_PAINT:    paint_reg  <= cfg_data[24:0];
                REG_CANVAS:   canvas_reg <= cfg_data[31:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        r2_reg    <= radius_reg * radius_reg;
        inner_reg <= inner_prod[39:16];
        opsat_reg <= (opac_reg > ONE_Q16) ? ONE_Q16 : opac_reg;
    end

    // stage 1: capture beat
    logic t1_valid_reg;
    in_t  t1_item_reg;

    // stage 2: canvas test and differences
    logic               t2_valid_reg;
    pix_t               t2_pix_reg;
    logic signed [24:0] t2_ux_reg, t2_uy_reg, t2_vx_reg, t2_vy_reg;
    logic signed [24:0] ux_next, uy_next, vx_next, vy_next;
    logic [23:0]        cw, ch;
    pix_t               pix_next;

    assign cw = {canvas_reg[15:0], 8'h00};
    assign ch = {canvas_reg[31:16], 8'h00};
    assign ux_next = $signed({t1_item_reg.pos_x[23], t1_item_reg.pos_x})
                   - $signed({start_reg[23], start_reg[23:0]});
    assign uy_next = $signed({t1_item_reg.pos_y[23], t1_item_reg.pos_y})
                   - $signed({start_reg[47], start_reg[47:24]});
    assign vx_next = $signed({end_reg[23], end_reg[23:0]})
                   - $signed({start_reg[23], start_reg[23:0]});
    assign vy_next = $signed({end_reg[47], end_reg[47:24]})
                   - $signed({start_reg[47], start_reg[47:24]});

    always_comb
    begin
        pix_next.orig_rgba     = t1_item_reg.orig_rgba;
        pix_next.prev_rgba     = t1_item_reg.prev_rgba;
        pix_next.prev_coverage = t1_item_reg.prev_coverage;
        pix_next.ok = !t1_item_reg.pos_x[23] && !t1_item_reg.pos_y[23]
                   && ($unsigned(t1_item_reg.pos_x) < cw)
                   && ($unsigned(t1_item_reg.pos_y) < ch);
    end

    // stage 3: products
    logic               t3_valid_reg;
    side_t_t            t3_side_reg;
    logic signed [49:0] t3_uxvx_reg, t3_uyvy_reg, t3_vxvx_reg, t3_vyvy_reg;

    // stage 4: dot product, squared length, projection select
    logic               t4_valid_reg;
    side_t_t            t4_side_reg;
    logic [TDIV_W-1:0]  t4_num_reg, t4_den_reg;
    logic signed [50:0] num_s;
    logic [50:0]        len;
    logic [1:0]         tmode_next;
    side_t_t            t4_side_next;

    assign num_s = t3_uxvx_reg + t3_uyvy_reg;
    assign len   = {1'b0, t3_vxvx_reg} + {1'b0, t3_vyvy_reg};

    always_comb
    begin
        if (len == '0 || num_s <= 0)
        begin
            tmode_next = T_ZERO;
        end
        else if ($unsigned(num_s) >= len)
        begin
            tmode_next = T_ONE;
        end
        else
        begin
            tmode_next = T_DIV;
        end
        t4_side_next       = t3_side_reg;
        t4_side_next.tmode = tmode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
            t4_valid_reg <= 1'b0;
        end
        else
        begin
            t1_valid_reg <= start && !busy;
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= t2_valid_reg;
            t4_valid_reg <= t3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_item_reg       <= item;
        t2_pix_reg        <= pix_next;
        t2_ux_reg         <= ux_next;
        t2_uy_reg         <= uy_next;
        t2_vx_reg         <= vx_next;
        t2_vy_reg         <= vy_next;
        t3_side_reg.pix   <= t2_pix_reg;
        t3_side_reg.ux    <= t2_ux_reg;
        t3_side_reg.uy    <= t2_uy_reg;
        t3_side_reg.vx    <= t2_vx_reg;
        t3_side_reg.vy    <= t2_vy_reg;
        t3_side_reg.tmode <= T_ZERO;
        t3_uxvx_reg       <= t2_ux_reg * t2_vx_reg;
        t3_uyvy_reg       <= t2_uy_reg * t2_vy_reg;
        t3_vxvx_reg       <= t2_vx_reg * t2_vx_reg;
        t3_vyvy_reg       <= t2_vy_reg * t2_vy_reg;
        t4_side_reg       <= t4_side_next;
        t4_num_reg        <= (tmode_next == T_DIV) ? $unsigned(num_s) : '0;
        t4_den_reg        <= (len == '0) ? 51'd1 : len;
    end

    logic          td_valid;
    logic [QW-1:0] td_quo;
    side_t_t       td_side;

    scbp_div #(.W(TDIV_W), .SB($bits(side_t_t))) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t4_valid_reg),
        .num       (t4_num_reg),
        .den       (t4_den_reg),
        .side_in   (t4_side_reg),
        .out_valid (td_valid),
        .quo       (td_quo),
        .side_out  (td_side)
    );

    // stage 5: t times direction
    logic               t5_valid_reg;
    pix_t               t5_pix_reg;
    logic signed [24:0] t5_ux_reg, t5_uy_reg;
    logic signed [42:0] t5_mx_reg, t5_my_reg;
    logic [16:0]        t_val;

    always_comb
    begin
        case (td_side.tmode)
            T_ONE:   t_val = ONE_Q16;
            T_DIV:   t_val = {1'b0, td_quo};
            default: t_val = '0;
        endcase
    end

    // stage 6: closest-point offset, rounded to Q.8
    logic               t6_valid_reg;
    pix_t               t6_pix_reg;
    logic signed [27:0] t6_dx_reg, t6_dy_reg;
    logic signed [43:0] fx, fy;

    assign fx = $signed({t5_ux_reg, 16'h0000}) - t5_mx_reg + 44'sd32768;
    assign fy = $signed({t5_uy_reg, 16'h0000}) - t5_my_reg + 44'sd32768;

    // stage 7: squares
    logic               t7_valid_reg;
    pix_t               t7_pix_reg;
    logic signed [55:0] t7_sx_reg, t7_sy_reg;

    // stage 8: squared distance and radius test
    logic               t8_valid_reg;
    pix_t               t8_pix_reg;
    logic [D2W-1:0]     t8_d2_reg;
    logic [56:0]        d2;
    pix_t               t8_pix_next;

    assign d2 = {1'b0, $unsigned(t7_sx_reg)} + {1'b0, $unsigned(t7_sy_reg)};

    always_comb
    begin
        t8_pix_next    = t7_pix_reg;
        t8_pix_next.ok = t7_pix_reg.ok && (d2 <= {9'h000, r2_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t5_valid_reg <= 1'b0;
            t6_valid_reg <= 1'b0;
            t7_valid_reg <= 1'b0;
            t8_valid_reg <= 1'b0;
        end
        else
        begin
            t5_valid_reg <= td_valid;
            t6_valid_reg <= t5_valid_reg;
            t7_valid_reg <= t6_valid_reg;
            t8_valid_reg <= t7_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t5_pix_reg <= td_side.pix;
        t5_ux_reg  <= td_side.ux;
        t5_uy_reg  <= td_side.uy;
        t5_mx_reg  <= td_side.vx * $signed({1'b0, t_val});
        t5_my_reg  <= td_side.vy * $signed({1'b0, t_val});
        t6_pix_reg <= t5_pix_reg;
        t6_dx_reg  <= fx[43:16];
        t6_dy_reg  <= fy[43:16];
        t7_pix_reg <= t6_pix_reg;
        t7_sx_reg  <= t6_dx_reg * t6_dx_reg;
        t7_sy_reg  <= t6_dy_reg * t6_dy_reg;
        t8_pix_reg <= t8_pix_next;
        t8_d2_reg  <= d2[D2W-1:0];
    end

    logic          sq_valid;
    logic [RW-1:0] sq_root;
    pix_t          sq_pix;

    scbp_sqrt #(.SB($bits(pix_t))) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t8_valid_reg),
        .val       (t8_d2_reg),
        .side_in   (t8_pix_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_pix)
    );

    // stage 9: soft band numerator and denominator
    logic              t9_valid_reg;
    side_c_t           t9_side_reg;
    logic [CDIV_W-1:0] t9_num_reg, t9_den_reg;
    logic              full;
    logic [CDIV_W-1:0] band;

    assign full = sq_root <= inner_reg;
    assign band = radius_reg - inner_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t9_valid_reg <= 1'b0;
        end
        else
        begin
            t9_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        t9_side_reg.pix  <= sq_pix;
        t9_side_reg.full <= full;
        t9_num_reg       <= (full || radius_reg <= sq_root) ? '0 : radius_reg - sq_root;
        t9_den_reg       <= (band == '0) ? 24'd1 : band;
    end

    logic          cd_valid;
    logic [QW-1:0] cd_quo;
    side_c_t       cd_side;

    scbp_div #(.W(CDIV_W), .SB($bits(side_c_t))) u_cdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t9_valid_reg),
        .num       (t9_num_reg),
        .den       (t9_den_reg),
        .side_in   (t9_side_reg),
        .out_valid (cd_valid),
        .quo       (cd_quo),
        .side_out  (cd_side)
    );

    scbp_blend u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cd_valid),
        .quo      (cd_quo),
        .side     (cd_side),
        .opacity  (opsat_reg),
        .paint    (paint_reg),
        .done     (done),
        .result   (result)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##Lat done)
        else $error("beat did not reach the output at the fixed latency");

    a_change_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.pixel_changed |-> result.write_enable)
        else $error("pixel change flagged without a write");

    a_write_coverage: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.write_enable |-> result.new_coverage != 17'd0
                                        && result.new_coverage <= ONE_Q16)
        else $error("written coverage out of range");

endmodule
